### rtl/core/cau_pkg.sv
// shared types, codes and tables for the complex arithmetic unit
package cau_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int ANG_BITS  = 24;
    localparam int ANG_ITERS = 24;
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);

    localparam logic signed [27:0] ANG_HALF_PI = 28'sd26353589;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_MAG = 3'd4;
    localparam logic [2:0] CMD_ARG = 3'd5;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_MAG,
        OP_ARG,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    typedef struct packed {
        op_t                       op;
        logic signed [DATA_W-1:0]  ar;
        logic signed [DATA_W-1:0]  ai;
        logic signed [DATA_W-1:0]  br;
        logic signed [DATA_W-1:0]  bi;
    } word_t;

    // atan(2^-i) in units of 2^-24 rad
    function automatic logic [23:0] cau_atan(input logic [4:0] i);
        logic [23:0] v;
        case (i)
            5'd0:    v = 24'd13176795;
            5'd1:    v = 24'd7778716;
            5'd2:    v = 24'd4110060;
            5'd3:    v = 24'd2086331;
            5'd4:    v = 24'd1047214;
            5'd5:    v = 24'd524117;
            5'd6:    v = 24'd262123;
            5'd7:    v = 24'd131069;
            5'd8:    v = 24'd65536;
            5'd9:    v = 24'd32768;
            5'd10:   v = 24'd16384;
            5'd11:   v = 24'd8192;
            5'd12:   v = 24'd4096;
            5'd13:   v = 24'd2048;
            5'd14:   v = 24'd1024;
            5'd15:   v = 24'd512;
            5'd16:   v = 24'd256;
            5'd17:   v = 24'd128;
            5'd18:   v = 24'd64;
            5'd19:   v = 24'd32;
            5'd20:   v = 24'd16;
            5'd21:   v = 24'd8;
            5'd22:   v = 24'd4;
            5'd23:   v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/cau_front.sv
// input stage: takes words, decodes the command and hands them to the queue
module cau_front
    import cau_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [2:0]               cmd,
    input  logic signed [DATA_W-1:0] a_re,
    input  logic signed [DATA_W-1:0] a_im,
    input  logic signed [DATA_W-1:0] b_re,
    input  logic signed [DATA_W-1:0] b_im,
    input  logic                     q_full,
    output logic                     q_wr,
    output word_t                    q_wdata
);

    logic  valid_reg;
    logic  valid_next;
    word_t word_reg;
    word_t word_next;
    logic  go;
    op_t   op_dec;

    always_comb
    begin
        case (cmd)
            CMD_ADD: op_dec = OP_ADD;
            CMD_SUB: op_dec = OP_SUB;
            CMD_MUL: op_dec = OP_MUL;
            CMD_DIV: op_dec = OP_DIV;
            CMD_MAG: op_dec = OP_MAG;
            CMD_ARG: op_dec = OP_ARG;
            default: op_dec = OP_NONE;
        endcase
    end

    assign go   = !valid_reg || !q_full;
    assign full = !go;

    always_comb
    begin
        word_next    = word_reg;
        valid_next   = valid_reg;
        if (go)
        begin
            valid_next   = push;
            word_next.op = op_dec;
            word_next.ar = a_re;
            word_next.ai = a_im;
            // unary operations do not look at b
            word_next.br = (op_dec == OP_MAG || op_dec == OP_ARG) ? '0 : b_re;
            word_next.bi = (op_dec == OP_MAG || op_dec == OP_ARG) ? '0 : b_im;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign q_wr    = valid_reg && !q_full;
    assign q_wdata = word_reg;

endmodule

### rtl/core/cau_queue.sv
// short word queue between the front stage and the arithmetic pipeline
module cau_queue
    import cau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr,
    input  word_t wdata,
    output logic  q_full,
    output logic  rd_valid,
    input  logic  rd,
    output word_t rdata
);

    word_t          data_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW-1:0] rd_ptr_next;
    logic [QAW:0]   cnt_reg;
    logic [QAW:0]   cnt_next;

    assign q_full   = (cnt_reg == (QAW+1)'(QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rdata    = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (QAW+1)'(wr) - (QAW+1)'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/core/cau_back.sv
// arithmetic pipeline: products, sums, dividers, square root, cordic, rounding
module cau_back
    import cau_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [31:0]              cfg_wdata,
    input  logic                     q_valid,
    input  word_t                    q_data,
    output logic                     q_pop,
    output logic                     empty,
    input  logic                     pop,
    output logic signed [DATA_W-1:0] res_re,
    output logic signed [DATA_W-1:0] res_im,
    output logic [1:0]               status
);

    localparam int IT0  = 4;
    localparam int ITN  = 2 * FRAC_W + 1;
    localparam int NSTG = IT0 + ITN + 1;
    localparam int LAST = NSTG - 1;

    typedef struct packed {
        op_t                 op;
        logic signed [31:0]  ar;
        logic signed [31:0]  ai;
        logic signed [31:0]  br;
        logic signed [31:0]  bi;
        logic signed [63:0]  p_rr;
        logic signed [63:0]  p_ii;
        logic signed [63:0]  p_ri;
        logic signed [63:0]  p_ir;
        logic signed [63:0]  p_b0;
        logic signed [63:0]  p_b1;
        logic signed [63:0]  p_a0;
        logic signed [63:0]  p_a1;
        logic signed [64:0]  n_re;
        logic signed [64:0]  n_im;
        logic [63:0]         den;
        logic [63:0]         sq_n;
        logic                neg_re;
        logic                neg_im;
        logic                dz;
        logic                big_re;
        logic                big_im;
        logic [63:0]         mag_re;
        logic [63:0]         mag_im;
        logic [63:0]         rem_re;
        logic [63:0]         rem_im;
        logic [32:0]         nlo_re;
        logic [32:0]         nlo_im;
        logic [32:0]         q_re;
        logic [32:0]         q_im;
        logic [63:0]         sq_rem;
        logic [63:0]         sq_r;
        logic signed [35:0]  cx;
        logic signed [35:0]  cy;
        logic [31:0]         cm;
        logic signed [27:0]  cz;
        logic                czero;
        logic [31:0]         o_re;
        logic [31:0]         o_im;
        status_t             o_st;
    } work_t;

    // saturate sign and magnitude into 32 bits, top bit flags saturation
    function automatic logic [32:0] sat_sm(input logic neg, input logic [63:0] mag);
        logic [32:0] r;
        if (!neg && mag > 64'h7FFF_FFFF)
        begin
            r = {1'b1, 32'h7FFF_FFFF};
        end
        else if (neg && mag > 64'h8000_0000)
        begin
            r = {1'b1, 32'h8000_0000};
        end
        else
        begin
            r = {1'b0, neg ? 32'(-mag) : mag[31:0]};
        end
        return r;
    endfunction

    function automatic work_t cau_step(input work_t w, input int s, input logic [31:0] eps);
        work_t              o;
        int                 j;
        int                 k;
        logic [79:0]        lim;
        logic [63:0]        t;
        logic [63:0]        bitv;
        logic [63:0]        tv;
        logic signed [35:0] xs;
        logic signed [35:0] ys;
        logic signed [32:0] sre;
        logic signed [32:0] sim;
        logic [63:0]        mr;
        logic [63:0]        mi;
        logic [32:0]        pr;
        logic [32:0]        pi;
        logic signed [27:0] z;
        logic               hit0;

        o    = w;
        j    = s - IT0;
        k    = 0;
        lim  = '0;
        t    = '0;
        bitv = '0;
        tv   = '0;
        xs   = '0;
        ys   = '0;
        sre  = '0;
        sim  = '0;
        mr   = '0;
        mi   = '0;
        pr   = '0;
        pi   = '0;
        z    = '0;
        hit0 = 1'b0;

        if (s == 0)
        begin
            o.p_rr  = w.ar * w.br;
            o.p_ii  = w.ai * w.bi;
            o.p_ri  = w.ar * w.bi;
            o.p_ir  = w.ai * w.br;
            o.p_b0  = w.br * w.br;
            o.p_b1  = w.bi * w.bi;
            o.p_a0  = w.ar * w.ar;
            o.p_a1  = w.ai * w.ai;
            o.cx    = 36'(w.ar);
            o.cy    = 36'(w.ai);
            o.cm    = (w.ar[31] ? 32'(-w.ar) : w.ar) | (w.ai[31] ? 32'(-w.ai) : w.ai);
            o.cz    = '0;
            o.czero = (w.ar == '0) && (w.ai == '0);
        end
        else if (s == 1)
        begin
            if (w.op == OP_DIV)
            begin
                o.n_re = 65'(w.p_rr) + 65'(w.p_ii);
                o.n_im = 65'(w.p_ir) - 65'(w.p_ri);
            end
            else
            begin
                o.n_re = 65'(w.p_rr) - 65'(w.p_ii);
                o.n_im = 65'(w.p_ri) + 65'(w.p_ir);
            end
            o.den  = w.p_b0 + w.p_b1;
            o.sq_n = w.p_a0 + w.p_a1;
        end
        else if (s == 2)
        begin
            o.neg_re = w.n_re[64];
            o.neg_im = w.n_im[64];
            o.mag_re = w.n_re[64] ? 64'(-w.n_re) : w.n_re[63:0];
            o.mag_im = w.n_im[64] ? 64'(-w.n_im) : w.n_im[63:0];
            o.dz     = (w.den <= {32'd0, eps});
        end
        else if (s == 3)
        begin
            // quotient above 2^15 cannot be represented
            lim      = ({16'd0, w.den} << 15) + {16'd0, w.den};
            o.big_re = ({16'd0, w.mag_re} >= lim);
            o.big_im = ({16'd0, w.mag_im} >= lim);
            o.rem_re = {16'd0, w.mag_re[63:16]};
            o.rem_im = {16'd0, w.mag_im[63:16]};
            o.nlo_re = {w.mag_re[15:0], 17'd0};
            o.nlo_im = {w.mag_im[15:0], 17'd0};
            o.q_re   = '0;
            o.q_im   = '0;
            o.sq_rem = w.sq_n;
            o.sq_r   = '0;
        end
        else if (s < LAST)
        begin
            // one restoring quotient bit per stage
            t = {w.rem_re[62:0], w.nlo_re[32]};
            if (t >= w.den)
            begin
                o.rem_re = t - w.den;
                o.q_re   = {w.q_re[31:0], 1'b1};
            end
            else
            begin
                o.rem_re = t;
                o.q_re   = {w.q_re[31:0], 1'b0};
            end
            o.nlo_re = {w.nlo_re[31:0], 1'b0};
            t = {w.rem_im[62:0], w.nlo_im[32]};
            if (t >= w.den)
            begin
                o.rem_im = t - w.den;
                o.q_im   = {w.q_im[31:0], 1'b1};
            end
            else
            begin
                o.rem_im = t;
                o.q_im   = {w.q_im[31:0], 1'b0};
            end
            o.nlo_im = {w.nlo_im[31:0], 1'b0};

            if (j < 32)
            begin
                bitv = 64'd1 << (62 - 2 * j);
                tv   = w.sq_r + bitv;
                if (w.sq_rem >= tv)
                begin
                    o.sq_rem = w.sq_rem - tv;
                    o.sq_r   = (w.sq_r >> 1) + bitv;
                end
                else
                begin
                    o.sq_r = w.sq_r >> 1;
                end
            end

            if (j < 5)
            begin
                // normalize so the larger part lands in [2^30, 2^31)
                k = 16 >> j;
                if (w.cm < (32'd1 << (31 - k)))
                begin
                    o.cm = w.cm << k;
                    o.cx = w.cx <<< k;
                    o.cy = w.cy <<< k;
                end
            end
            else if (j == 5)
            begin
                if (w.cx < 0)
                begin
                    if (w.cy >= 0)
                    begin
                        o.cx = w.cy;
                        o.cy = -w.cx;
                        o.cz = ANG_HALF_PI;
                    end
                    else
                    begin
                        o.cx = -w.cy;
                        o.cy = w.cx;
                        o.cz = -ANG_HALF_PI;
                    end
                end
            end
            else if (j < 6 + ANG_ITERS)
            begin
                xs = w.cx >>> (j - 6);
                ys = w.cy >>> (j - 6);
                if (w.cy > 0)
                begin
                    o.cx = w.cx + ys;
                    o.cy = w.cy - xs;
                    o.cz = w.cz + $signed({4'd0, cau_atan(5'(j - 6))});
                end
                else
                begin
                    o.cx = w.cx - ys;
                    o.cy = w.cy + xs;
                    o.cz = w.cz - $signed({4'd0, cau_atan(5'(j - 6))});
                end
            end
        end
        else
        begin
            pr = '0;
            pi = '0;
            case (w.op)
                OP_ADD, OP_SUB:
                begin
                    sre = (w.op == OP_ADD) ? 33'(w.ar) + 33'(w.br) : 33'(w.ar) - 33'(w.br);
                    sim = (w.op == OP_ADD) ? 33'(w.ai) + 33'(w.bi) : 33'(w.ai) - 33'(w.bi);
                    pr  = sat_sm(sre[32], sre[32] ? {31'd0, 33'(-sre)} : {31'd0, sre});
                    pi  = sat_sm(sim[32], sim[32] ? {31'd0, 33'(-sim)} : {31'd0, sim});
                end
                OP_MUL:
                begin
                    mr = (w.mag_re + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
                    mi = (w.mag_im + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
                    pr = sat_sm(w.neg_re, mr);
                    pi = sat_sm(w.neg_im, mi);
                end
                OP_DIV:
                begin
                    if (w.dz)
                    begin
                        hit0 = 1'b1;
                    end
                    else
                    begin
                        mr = w.big_re ? 64'h7FFF_FFFF_FFFF_FFFF
                                      : ({31'd0, w.q_re} + 64'd1) >> 1;
                        mi = w.big_im ? 64'h7FFF_FFFF_FFFF_FFFF
                                      : ({31'd0, w.q_im} + 64'd1) >> 1;
                        pr = sat_sm(w.neg_re && (mr != '0), mr);
                        pi = sat_sm(w.neg_im && (mi != '0), mi);
                        pr[32] = pr[32] | w.big_re;
                        pi[32] = pi[32] | w.big_im;
                    end
                end
                OP_MAG:
                begin
                    mr = (w.sq_rem > w.sq_r) ? w.sq_r + 64'd1 : w.sq_r;
                    pr = sat_sm(1'b0, mr);
                end
                OP_ARG:
                begin
                    z  = w.czero ? '0 : w.cz;
                    mr = {36'd0, z[27] ? 28'(-z) : z};
                    mr = (mr + (64'd1 << (ANG_BITS - FRAC_W - 1))) >> (ANG_BITS - FRAC_W);
                    pr = sat_sm(z[27], mr);
                end
                default:
                begin
                    pr = '0;
                end
            endcase
            o.o_re = pr[31:0];
            o.o_im = pi[31:0];
            if (hit0)
            begin
                o.o_st = ST_DIV0;
            end
            else if (pr[32] || pi[32])
            begin
                o.o_st = ST_SAT;
            end
            else
            begin
                o.o_st = ST_OK;
            end
        end
        return o;
    endfunction

    logic [31:0] eps_reg;
    work_t       stg_reg  [NSTG];
    work_t       stg_next [NSTG];
    logic        v_reg    [NSTG];
    work_t       w0;
    logic        adv;

    assign adv   = !v_reg[LAST] || pop;
    assign q_pop = adv && q_valid;

    always_comb
    begin
        w0    = '0;
        w0.op = q_data.op;
        w0.ar = q_data.ar;
        w0.ai = q_data.ai;
        w0.br = q_data.br;
        w0.bi = q_data.bi;
    end

    for (genvar s = 0; s < NSTG; s++)
    begin : g_stage
        if (s == 0)
        begin : g_first
            always_comb
            begin
                stg_next[s] = cau_step(w0, s, eps_reg);
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else if (adv)
                begin
                    v_reg[s] <= q_valid;
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                stg_next[s] = cau_step(stg_reg[s-1], s, eps_reg);
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else if (adv)
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                stg_reg[s] <= stg_next[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= '0;
        end
        else if (cfg_we)
        begin
            eps_reg <= cfg_wdata;
        end
    end

    assign empty  = !v_reg[LAST];
    assign res_re = stg_reg[LAST].o_re;
    assign res_im = stg_reg[LAST].o_im;
    assign status = stg_reg[LAST].o_st;

`ifndef SYNTHESIS
    a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[LAST] && stg_reg[LAST].o_st == ST_DIV0)
            |-> (stg_reg[LAST].op == OP_DIV && res_re == '0 && res_im == '0))
        else $error("division fault word carries a nonzero result");

    a_unary_im: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[LAST] && (stg_reg[LAST].op == OP_MAG || stg_reg[LAST].op == OP_ARG))
            |-> (res_im == '0))
        else $error("unary operation with nonzero imaginary part");

    a_mag_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[LAST] && stg_reg[LAST].op == OP_MAG) |-> !res_re[DATA_W-1])
        else $error("negative magnitude");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv) |=> (v_reg[LAST] && $stable(stg_reg[0]) && $stable(stg_reg[LAST])))
        else $error("pipeline moved while stalled");
`endif

endmodule

### rtl/core/complex_arithmetic_unit_core.sv
// top level of the complex arithmetic unit
//
//  channel  | ports                               | handshake
//  ---------+-------------------------------------+-----------------------------
//  input    | cmd, a_re, a_im, b_re, b_im         | taken when push && !full
//  result   | res_re, res_im, status              | taken when pop && !empty
//  config   | cfg_wdata (div_epsilon)             | written when cfg_we
//
// one word per clock sustained while results are popped; a word passes from push to result
// through the front register, the queue and the 38-stage pipeline set by the 33 quotient-bit stages
// a stalled result freezes the whole pipeline; the queue and front keep
// taking words until 5 are waiting
// reset clears all valid flags and div_epsilon, no clearing pass
module complex_arithmetic_unit_core
    import cau_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [2:0]               cmd,
    input  logic signed [DATA_W-1:0] a_re,
    input  logic signed [DATA_W-1:0] a_im,
    input  logic signed [DATA_W-1:0] b_re,
    input  logic signed [DATA_W-1:0] b_im,
    output logic                     empty,
    input  logic                     pop,
    output logic signed [DATA_W-1:0] res_re,
    output logic signed [DATA_W-1:0] res_im,
    output logic [1:0]               status,
    input  logic                     cfg_we,
    input  logic [31:0]              cfg_wdata
);

    logic  q_full;
    logic  q_wr;
    word_t q_wdata;
    logic  q_valid;
    logic  q_pop;
    word_t q_rdata;

    cau_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .cmd     (cmd),
        .a_re    (a_re),
        .a_im    (a_im),
        .b_re    (b_re),
        .b_im    (b_im),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_wdata (q_wdata)
    );

    cau_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wdata    (q_wdata),
        .q_full   (q_full),
        .rd_valid (q_valid),
        .rd       (q_pop),
        .rdata    (q_rdata)
    );

    cau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .res_re    (res_re),
        .res_im    (res_im),
        .status    (status)
    );

endmodule

### sim/cau_checker.sv
// scoreboard for the complex arithmetic unit: predicts each word and checks the results
module cau_checker
    import cau_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic                     full,
    input  logic [2:0]               cmd,
    input  logic signed [DATA_W-1:0] a_re,
    input  logic signed [DATA_W-1:0] a_im,
    input  logic signed [DATA_W-1:0] b_re,
    input  logic signed [DATA_W-1:0] b_im,
    input  logic                     empty,
    input  logic                     pop,
    input  logic signed [DATA_W-1:0] res_re,
    input  logic signed [DATA_W-1:0] res_im,
    input  logic [1:0]               status,
    input  logic                     cfg_we,
    input  logic [31:0]              cfg_wdata,
    output int                       errors,
    output int                       pending,
    output int                       results_seen,
    output int                       div0_seen,
    output int                       sat_seen
);

    typedef struct {
        logic [2:0]  op;
        logic [31:0] re;
        logic [31:0] im;
        status_t     st;
    } cplx_res_t;

    cplx_res_t   res_q[$];
    logic [31:0] eps;

    function automatic logic [63:0] mag_split(input longint s, output bit neg);
        neg = s < 0;
        return neg ? 64'd0 - 64'(s) : 64'(s);
    endfunction

    // exact sum of two products as sign and magnitude
    function automatic logic [63:0] sum_split(input longint p1, input longint p2,
                                              output bit neg);
        if (p1 >= 0 && p2 >= 0)
        begin
            neg = 0;
            return 64'(p1) + 64'(p2);
        end
        if (p1 < 0 && p2 < 0)
        begin
            neg = 1;
            return (64'd0 - 64'(p1)) + (64'd0 - 64'(p2));
        end
        return mag_split(p1 + p2, neg);
    endfunction

    function automatic logic [31:0] sat_pack(input bit neg, input logic [63:0] mag,
                                             inout bit sat);
        logic [63:0] m;
        m = mag;
        if (!neg && m > 64'h7fff_ffff)
        begin
            sat = 1;
            m = 64'h7fff_ffff;
        end
        else if (neg && m > 64'h8000_0000)
        begin
            sat = 1;
            m = 64'h8000_0000;
        end
        return neg ? 32'(64'd0 - m) : m[31:0];
    endfunction

    function automatic logic [63:0] rnd_shift(input logic [63:0] mag, input int sh);
        return (mag + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic logic [63:0] frac_div(input logic [63:0] num, input logic [63:0] den,
                                             output bit big);
        logic [63:0] q, r;
        q = num / den;
        r = num % den;
        big = 0;
        if (q > (64'd1 << (DATA_W - 1 - FRAC_W)))
        begin
            big = 1;
            return 64'h7fff_ffff_ffff_ffff;
        end
        for (int i = 0; i <= FRAC_W; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return (q + 64'd1) >> 1;
    endfunction

    function automatic cplx_res_t predict(input logic [2:0] op,
                                          input logic signed [31:0] ar32,
                                          input logic signed [31:0] ai32,
                                          input logic signed [31:0] br32,
                                          input logic signed [31:0] bi32,
                                          input logic [31:0] thr);
        cplx_res_t   o;
        longint      ar, ai, br, bi, x, y, z, t, xs, ys;
        logic [63:0] mr, mi, den, n, r, b;
        bit          nr, ni, sat, big;
        ar = ar32;
        ai = ai32;
        br = br32;
        bi = bi32;
        sat = 0;
        o.op = op;
        o.re = '0;
        o.im = '0;
        o.st = ST_OK;
        case (op)
            CMD_ADD, CMD_SUB:
            begin
                mr = mag_split(op == CMD_ADD ? ar + br : ar - br, nr);
                mi = mag_split(op == CMD_ADD ? ai + bi : ai - bi, ni);
                o.re = sat_pack(nr, mr, sat);
                o.im = sat_pack(ni, mi, sat);
            end
            CMD_MUL:
            begin
                mr = sum_split(ar * br, -(ai * bi), nr);
                mi = sum_split(ar * bi, ai * br, ni);
                o.re = sat_pack(nr, rnd_shift(mr, FRAC_W), sat);
                o.im = sat_pack(ni, rnd_shift(mi, FRAC_W), sat);
            end
            CMD_DIV:
            begin
                den = 64'(br * br) + 64'(bi * bi);
                if (den <= {32'd0, thr})
                    o.st = ST_DIV0;
                else
                begin
                    mr = sum_split(ar * br, ai * bi, nr);
                    mi = sum_split(ai * br, -(ar * bi), ni);
                    mr = frac_div(mr, den, big);
                    if (big)
                        sat = 1;
                    mi = frac_div(mi, den, big);
                    if (big)
                        sat = 1;
                    o.re = sat_pack(nr && mr != 0, mr, sat);
                    o.im = sat_pack(ni && mi != 0, mi, sat);
                end
            end
            CMD_MAG:
            begin
                n = 64'(ar * ar) + 64'(ai * ai);
                r = 0;
                b = 64'd1 << 62;
                while (b > n)
                    b = b >> 2;
                while (b != 0)
                begin
                    if (n >= r + b)
                    begin
                        n = n - (r + b);
                        r = (r >> 1) + b;
                    end
                    else
                        r = r >> 1;
                    b = b >> 2;
                end
                o.re = sat_pack(0, n > r ? r + 1 : r, sat);
            end
            CMD_ARG:
            begin
                x = ar;
                y = ai;
                z = 0;
                if (x != 0 || y != 0)
                begin
                    // normalize so the larger part reaches 2^30
                    while ((x < 0 ? -x : x) < (64'sd1 <<< 30) &&
                           (y < 0 ? -y : y) < (64'sd1 <<< 30))
                    begin
                        x = x * 2;
                        y = y * 2;
                    end
                    if (x < 0)
                    begin
                        t = x;
                        if (y >= 0)
                        begin
                            x = y;
                            y = -t;
                            z = ANG_HALF_PI;
                        end
                        else
                        begin
                            x = -y;
                            y = t;
                            z = -ANG_HALF_PI;
                        end
                    end
                    for (int i = 0; i < ANG_ITERS; i++)
                    begin
                        xs = x >>> i;
                        ys = y >>> i;
                        if (y > 0)
                        begin
                            x = x + ys;
                            y = y - xs;
                            z = z + longint'(cau_atan(5'(i)));
                        end
                        else
                        begin
                            x = x - ys;
                            y = y + xs;
                            z = z - longint'(cau_atan(5'(i)));
                        end
                    end
                end
                mr = mag_split(z, nr);
                o.re = sat_pack(nr, rnd_shift(mr, ANG_BITS - FRAC_W), sat);
            end
            default: ;
        endcase
        if (sat)
            o.st = ST_SAT;
        return o;
    endfunction

    task automatic report(input string what, input logic [2:0] op,
                          input logic [31:0] got, input logic [31:0] want);
        $display("mismatch on %s (op %0d): got %h, want %h at %0t", what, op, got, want,
                 $time);
        errors++;
    endtask

    assign pending = res_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        cplx_res_t w;
        if (!rst_n)
        begin
            eps <= '0;
            res_q.delete();
            errors = 0;
            results_seen = 0;
            div0_seen = 0;
            sat_seen = 0;
        end
        else
        begin
            if (cfg_we)
                eps <= cfg_wdata;
            if (push && !full)
                res_q.push_back(predict(cmd, a_re, a_im, b_re, b_im, eps));
            if (pop && !empty)
            begin
                if (res_q.size() == 0)
                begin
                    $display("result word with nothing expected at %0t", $time);
                    errors++;
                end
                else
                begin
                    w = res_q.pop_front();
                    results_seen++;
                    if (w.st == ST_DIV0)
                        div0_seen++;
                    if (w.st == ST_SAT)
                        sat_seen++;
                    if (res_re !== w.re)
                        report("res_re", w.op, res_re, w.re);
                    if (res_im !== w.im)
                        report("res_im", w.op, res_im, w.im);
                    if (status !== w.st)
                        report("status", w.op, 32'(status), 32'(w.st));
                end
            end
        end
    end

endmodule

### sim/tb.sv
// testbench top for the complex arithmetic unit: clock, reset, stimulus and verdict
module tb;
    import cau_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     push;
    logic                     full;
    logic [2:0]               cmd;
    logic signed [DATA_W-1:0] a_re, a_im, b_re, b_im;
    logic                     empty;
    logic                     pop;
    logic signed [DATA_W-1:0] res_re, res_im;
    logic [1:0]               status;
    logic                     cfg_we;
    logic [31:0]              cfg_wdata;

    int errors, pending, results_seen, div0_seen, sat_seen;
    int words_sent;
    bit no_idle;
    bit hold_req;

    complex_arithmetic_unit_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .empty     (empty),
        .pop       (pop),
        .res_re    (res_re),
        .res_im    (res_im),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    cau_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .a_re         (a_re),
        .a_im         (a_im),
        .b_re         (b_re),
        .b_im         (b_im),
        .empty        (empty),
        .pop          (pop),
        .res_re       (res_re),
        .res_im       (res_im),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen),
        .div0_seen    (div0_seen),
        .sat_seen     (sat_seen)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("timeout");
        $display("FAILURE");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int held;
        pop = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                pop <= 0;
                for (held = 0; held < 300; held++)
                    @(posedge clk);
                hold_req = 0;
            end
            pop <= no_idle || ($urandom_range(99) >= 22);
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(262143)) - 131072);
            2:       return 32'($signed($urandom_range(511)) - 256);
            3:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(33554431)) - 16777216);
        endcase
    endfunction

    task automatic send_word(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
                             input logic [31:0] br, input logic [31:0] bi);
        // each cycle idles with the same small chance
        while (!no_idle && $urandom_range(99) < 22)
        begin
            push <= 0;
            @(posedge clk);
        end
        push <= 1;
        cmd  <= op;
        a_re <= ar;
        a_im <= ai;
        b_re <= br;
        b_im <= bi;
        @(negedge clk);
        while (full)
            @(negedge clk);
        @(posedge clk);
        words_sent++;
    endtask

    task automatic drain();
        push <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (45) @(posedge clk);
    endtask

    task automatic set_epsilon(input logic [31:0] v);
        cfg_we    <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 0;
    endtask

    task automatic send_random();
        logic [2:0] op;
        op = ($urandom_range(49) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
        send_word(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    endtask

    initial
    begin
        logic [31:0] eps_list[4];
        rst_n     = 0;
        push      = 0;
        cmd       = CMD_ADD;
        a_re      = '0;
        a_im      = '0;
        b_re      = '0;
        b_im      = '0;
        cfg_we    = 0;
        cfg_wdata = '0;
        words_sent = 0;
        no_idle   = 0;
        hold_req  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed corners with the reset threshold of zero
        send_word(CMD_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_word(CMD_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        send_word(CMD_ADD, 32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 32'h0000_0001);
        send_word(CMD_SUB, 32'h0000_0000, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0001);
        send_word(CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_word(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(CMD_MUL, 32'h0002_0000, 32'hffff_8000, 32'h0000_8000, 32'h0001_0000);
        send_word(CMD_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
        send_word(CMD_DIV, 32'h0003_0000, 32'hfffe_0000, 32'h0001_0000, 32'h0001_0000);
        send_word(CMD_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
        send_word(CMD_DIV, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff);
        send_word(CMD_DIV, 32'h0000_0001, 32'h0000_0000, 32'h7fff_ffff, 32'h0000_0000);
        send_word(CMD_MAG, 32'h8000_0000, 32'h8000_0000, 32'h1234_5678, 32'h0);
        send_word(CMD_MAG, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0);
        send_word(CMD_MAG, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(CMD_ARG, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(CMD_ARG, 32'hffff_0000, 32'h0, 32'h0, 32'h0);
        send_word(CMD_ARG, 32'hffff_0000, 32'hffff_ffff, 32'h0, 32'h0);
        send_word(CMD_ARG, 32'h0, 32'h8000_0000, 32'h0, 32'h0);
        send_word(CMD_ARG, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0);
        send_word(CMD_ARG, 32'h8000_0000, 32'h0000_0001, 32'h0, 32'h0);
        send_word(CMD_ARG, 32'h0000_0001, 32'hffff_ffff, 32'h0, 32'h0);
        send_word(3'd6, 32'h1, 32'h2, 32'h3, 32'h4);
        send_word(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        drain();

        eps_list[0] = 32'hffff_ffff;
        eps_list[1] = 32'($urandom);
        eps_list[2] = 32'h0010_0000;
        eps_list[3] = 32'h0000_0000;
        for (int ph = 0; ph < 4; ph++)
        begin
            set_epsilon(eps_list[ph]);
            no_idle = (ph == 2);
            for (int k = 0; k < 355; k++)
            begin
                if (ph == 1 && k == 100)
                    hold_req = 1;
                // sender waits for everything to come back once
                if (ph == 3 && k == 150)
                begin
                    push <= 0;
                    @(posedge clk);
                    while (pending != 0)
                        @(posedge clk);
                end
                send_random();
            end
            drain();
        end
        no_idle = 0;

        $display("sent %0d words across five threshold settings, %0d results checked",
                 words_sent, results_seen);
        $display("division-by-zero results %0d, saturated results %0d", div0_seen, sat_seen);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
